// File: sv/drfp_pkg.sv
// ----------------------------------------------------------------------------
// drfp_pkg: shared types, constants and CRC helper
// Register indexes, frame layout, the queue entry type and a one-byte
// CRC-8 update used by the range frame parser.
// ----------------------------------------------------------------------------
package drfp_pkg;

	localparam int FRAME_BYTES = 7;
	localparam int SHORT_BYTES = 4;
	localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
	localparam int IDX_W       = $clog2(FRAME_BYTES);

	// byte positions inside a frame
	localparam int OPT_HI_POS = 1;
	localparam int OPT_LO_POS = 2;
	localparam int SON_HI_POS = 3;
	localparam int SON_LO_POS = 4;

	localparam logic [7:0] SYNC_BYTE = 8'h54;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPTICAL_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPTICAL_MAX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SONAR_MIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SONAR_MAX   = 3'd4;

	localparam logic [7:0]  RST_CRC_POLY    = 8'h07;
	localparam logic [15:0] RST_OPTICAL_MIN = 16'd200;
	localparam logic [15:0] RST_OPTICAL_MAX = 16'd14000;
	localparam logic [15:0] RST_SONAR_MIN   = 16'd50;
	localparam logic [15:0] RST_SONAR_MAX   = 16'd7650;

	localparam logic KIND_OPTICAL = 1'b0;
	localparam logic KIND_SONAR   = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0]  crc_poly;
		logic [15:0] optical_min;
		logic [15:0] optical_max;
		logic [15:0] sonar_min;
		logic [15:0] sonar_max;
	} cfg_t;

	// one frame that passed its CRC check
	typedef struct packed {
		logic        dual;
		logic [15:0] optical;
		logic [15:0] sonar;
	} frame_t;

	// MSB-first CRC-8 update over one byte, no reflection
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
		input logic [7:0] data, input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// File: sv/drfp_front.sv
// ----------------------------------------------------------------------------
// drfp_front: byte intake and frame classification
// Collects bytes into the frame store with a running CRC and pushes frames
// whose CRC matches into the queue.
// ----------------------------------------------------------------------------
module drfp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            crc_poly,
	input  logic                  poly_wr,
	input  logic                  queue_full,
	output logic                  push,
	output drfp_pkg::frame_t      push_data
);

	logic [7:0]                   store_q [drfp_pkg::FRAME_BYTES];
	logic [drfp_pkg::FILL_W-1:0]  fill_q;
	logic [7:0]                   crc_q;
	logic [7:0]                   crc_lag_q;
	logic                         rc_busy_q;
	logic [drfp_pkg::FILL_W-1:0]  rc_idx_q;

	logic accept;
	logic is_sync;
	logic append;
	logic restart;
	logic short_ok;
	logic long_ok;

	assign in_stall = queue_full || rc_busy_q;

	always_comb begin
		accept   = in_valid && !in_stall;
		is_sync  = (rx_byte == drfp_pkg::SYNC_BYTE);
		append   = accept && !is_sync &&
			(fill_q < drfp_pkg::FILL_W'(drfp_pkg::FRAME_BYTES));
		restart  = accept && !append;
		short_ok = (fill_q == drfp_pkg::FILL_W'(drfp_pkg::SHORT_BYTES)) &&
			(crc_lag_q == store_q[drfp_pkg::SHORT_BYTES-1]);
		long_ok  = (fill_q == drfp_pkg::FILL_W'(drfp_pkg::FRAME_BYTES)) &&
			(crc_lag_q == store_q[drfp_pkg::FRAME_BYTES-1]);
		push     = accept && is_sync && (short_ok || long_ok);
		push_data.dual    = long_ok;
		push_data.optical = {store_q[drfp_pkg::OPT_HI_POS], store_q[drfp_pkg::OPT_LO_POS]};
		push_data.sonar   = {store_q[drfp_pkg::SON_HI_POS], store_q[drfp_pkg::SON_LO_POS]};
	end

	// frame bytes: only positions below fill_q are ever read
	always_ff @(posedge clk) begin
		if (restart) begin
			store_q[0] <= drfp_pkg::SYNC_BYTE;
		end else if (append) begin
			store_q[fill_q[drfp_pkg::IDX_W-1:0]] <= rx_byte;
		end
	end

	// crc_q covers all held bytes, crc_lag_q all but the newest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			crc_q     <= '0;
			crc_lag_q <= '0;
			rc_busy_q <= 1'b0;
			rc_idx_q  <= '0;
		end else if (poly_wr) begin
			// rebuild the running CRC under the new polynomial
			rc_busy_q <= 1'b1;
			rc_idx_q  <= '0;
			crc_q     <= '0;
			crc_lag_q <= '0;
		end else if (rc_busy_q) begin
			if (rc_idx_q == fill_q) begin
				rc_busy_q <= 1'b0;
			end else begin
				crc_lag_q <= crc_q;
				crc_q     <= drfp_pkg::crc8_byte(crc_q,
					store_q[rc_idx_q[drfp_pkg::IDX_W-1:0]], crc_poly);
				rc_idx_q  <= rc_idx_q + drfp_pkg::FILL_W'(1);
			end
		end else if (restart) begin
			fill_q    <= drfp_pkg::FILL_W'(1);
			crc_lag_q <= '0;
			crc_q     <= drfp_pkg::crc8_byte(8'h00, drfp_pkg::SYNC_BYTE, crc_poly);
		end else if (append) begin
			fill_q    <= fill_q + drfp_pkg::FILL_W'(1);
			crc_lag_q <= crc_q;
			crc_q     <= drfp_pkg::crc8_byte(crc_q, rx_byte, crc_poly);
		end
	end

endmodule

// File: sv/drfp_queue.sv
// ----------------------------------------------------------------------------
// drfp_queue: short frame queue
// Two-entry FIFO of checked frames between the intake and the emitter.
// ----------------------------------------------------------------------------
module drfp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  drfp_pkg::frame_t      push_data,
	output logic                  full,
	input  logic                  pop,
	output drfp_pkg::frame_t      pop_data,
	output logic                  empty
);

	drfp_pkg::frame_t             slot_q [drfp_pkg::QUEUE_DEPTH];
	logic [drfp_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [drfp_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [drfp_pkg::QCNT_W-1:0]  count_q;

	logic do_push;
	logic do_pop;

	assign full     = (count_q == drfp_pkg::QCNT_W'(drfp_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + drfp_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + drfp_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + drfp_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - drfp_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// File: sv/drfp_back.sv
// ----------------------------------------------------------------------------
// drfp_back: window check and result emitter
// Pops checked frames, applies the range windows, numbers optical readings
// and drives the result output register.
// ----------------------------------------------------------------------------
module drfp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  drfp_pkg::cfg_t        cfg,
	input  logic                  empty,
	input  drfp_pkg::frame_t      pop_data,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  sensor_kind,
	output logic [15:0]           range_mm,
	output logic [31:0]           sequence_res,
	output logic                  last
);

	localparam logic [1:0] S_IDLE     = 2'd0;
	localparam logic [1:0] S_EMIT_OPT = 2'd1;
	localparam logic [1:0] S_EMIT_SON = 2'd2;

	logic [1:0]  state_q;
	logic [15:0] opt_range_q;
	logic [15:0] son_range_q;
	logic        son_go_q;
	logic [31:0] seq_q;

	logic        out_valid_q;
	logic        kind_q;
	logic [15:0] range_q;
	logic [31:0] seq_out_q;
	logic        last_q;

	logic opt_go;
	logic son_go;
	logic slot_free;
	logic emit;

	assign out_valid    = out_valid_q;
	assign sensor_kind  = kind_q;
	assign range_mm     = range_q;
	assign sequence_res = seq_out_q;
	assign last         = last_q;

	always_comb begin
		pop       = (state_q == S_IDLE) && !empty;
		opt_go    = (pop_data.optical >= cfg.optical_min) &&
			(pop_data.optical <= cfg.optical_max);
		son_go    = pop_data.dual && (pop_data.sonar >= cfg.sonar_min) &&
			(pop_data.sonar <= cfg.sonar_max);
		slot_free = !out_valid_q || !out_stall;
		emit      = slot_free && ((state_q == S_EMIT_OPT) || (state_q == S_EMIT_SON));
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			opt_range_q <= pop_data.optical;
			son_range_q <= pop_data.sonar;
			son_go_q    <= son_go;
		end
		if (slot_free && state_q == S_EMIT_OPT) begin
			kind_q    <= drfp_pkg::KIND_OPTICAL;
			range_q   <= opt_range_q;
			seq_out_q <= seq_q;
			last_q    <= !son_go_q;
		end else if (slot_free && state_q == S_EMIT_SON) begin
			kind_q    <= drfp_pkg::KIND_SONAR;
			range_q   <= son_range_q;
			seq_out_q <= seq_q;
			last_q    <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seq_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, or drop the one just taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (opt_go) begin
							state_q <= S_EMIT_OPT;
						end else if (son_go) begin
							state_q <= S_EMIT_SON;
						end
					end
				end
				S_EMIT_OPT: begin
					if (slot_free) begin
						seq_q   <= seq_q + 32'd1;
						state_q <= son_go_q ? S_EMIT_SON : S_IDLE;
					end
				end
				S_EMIT_SON: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/dual_range_frame_parser_crc8_core.sv
// ----------------------------------------------------------------------------
// dual_range_frame_parser_crc8_core: CRC-8 checked serial range frame parser
// Takes one serial byte per item and emits optical and ultrasonic ranges
// from frames that pass their CRC and fall inside the range windows.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while in_stall is low.
// Bytes other than 'T' fill a seven-byte frame store; a 'T' closes the held
// frame. The intake keeps a running CRC-8 over the stored bytes, so a
// closing 'T' is checked in the cycle it arrives and a good frame drops
// into a two-entry queue. The emitter pops a frame, applies the optical and
// ultrasonic windows and sends up to two results through its state
// register and an output register. in_stall rises only when the queue is
// full (a stalled output side backs up) and after a write to crc_poly,
// while the running CRC is rebuilt over the bytes already held under the
// new polynomial. Optical results carry the shared sequence number and
// advance it; an ultrasonic result carries the number after any optical
// advance. last marks the final result caused by a byte. Write
// configuration only while the block is idle.
module dual_range_frame_parser_crc8_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        rx_byte,
	input  logic                              cfg_we,
	input  logic [drfp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [drfp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              sensor_kind,
	output logic [15:0]                       range_mm,
	output logic [31:0]                       sequence_res,
	output logic                              last
);

	drfp_pkg::cfg_t   cfg_q;
	drfp_pkg::frame_t push_data;
	drfp_pkg::frame_t pop_data;
	logic             poly_wr;
	logic             push;
	logic             pop;
	logic             queue_full;
	logic             queue_empty;

	// a polynomial write forces the intake to rebuild its running CRC
	assign poly_wr = cfg_we && (cfg_index == drfp_pkg::REG_CRC_POLY);

	// configuration registers; writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_poly    <= drfp_pkg::RST_CRC_POLY;
			cfg_q.optical_min <= drfp_pkg::RST_OPTICAL_MIN;
			cfg_q.optical_max <= drfp_pkg::RST_OPTICAL_MAX;
			cfg_q.sonar_min   <= drfp_pkg::RST_SONAR_MIN;
			cfg_q.sonar_max   <= drfp_pkg::RST_SONAR_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				drfp_pkg::REG_CRC_POLY:    cfg_q.crc_poly    <= cfg_data[7:0];
				drfp_pkg::REG_OPTICAL_MIN: cfg_q.optical_min <= cfg_data;
				drfp_pkg::REG_OPTICAL_MAX: cfg_q.optical_max <= cfg_data;
				drfp_pkg::REG_SONAR_MIN:   cfg_q.sonar_min   <= cfg_data;
				drfp_pkg::REG_SONAR_MAX:   cfg_q.sonar_max   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// intake: store bytes, track CRC, classify closed frames
	drfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.crc_poly   (cfg_q.crc_poly),
		.poly_wr    (poly_wr),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	// decouple intake from the emitter
	drfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (queue_empty)
	);

	// emitter: window checks, sequence numbering, output register
	drfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.empty        (queue_empty),
		.pop_data     (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sensor_kind  (sensor_kind),
		.range_mm     (range_mm),
		.sequence_res (sequence_res),
		.last         (last)
	);

endmodule

// File: sv/drfp_checker.sv
// ----------------------------------------------------------------------------
// drfp_checker: port-level checks for the range frame parser
// Watches the result channel for pairing and numbering of results.
// ----------------------------------------------------------------------------
module drfp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        sensor_kind,
	input  logic [15:0] range_mm,
	input  logic [31:0] sequence_res,
	input  logic        last
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(range_mm) &&
		$stable(sequence_res) && $stable(sensor_kind) && $stable(last))
		else $error("stalled result changed");

	// an ultrasonic result always closes its byte's results
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sensor_kind |-> last)
		else $error("ultrasonic result not marked last");

	// an optical result not marked last is followed at once by its sonar mate
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && sensor_kind && last)
		else $error("missing ultrasonic result after optical");

	// the sonar mate carries the number after the optical advance
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
		sequence_res == $past(sequence_res) + 32'd1)
		else $error("ultrasonic sequence number not advanced");

endmodule

bind dual_range_frame_parser_crc8_core drfp_checker u_drfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sensor_kind  (sensor_kind),
	.range_mm     (range_mm),
	.sequence_res (sequence_res),
	.last         (last)
);
